[sv/bffa_pkg.sv]
package bffa_pkg;

    localparam int DEF_POOL_BYTES = 256;
    localparam int DEF_ELEM_BYTES = 24;
    localparam int ROW_BYTES      = 8;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_CLR,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic scan;
        logic mark;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic free_ok;
        logic found;
        logic scan_last;
        logic mark_last;
        logic clr_last;
        logic out_free;
    } stat_t;

endpackage

[sv/bitmap_first_fit_allocator_core.sv]
// First-fit byte pool allocator, one occupancy bit per pool byte.
// Input channel (s_valid/s_ready): s_req_type 0 allocates one element, 1 frees the
// element at s_offset, 2 empties the map; code 3 is a no-op that reports failure.
// Result channel (m_valid/m_ready): exactly one transfer per request, m_ok and
// m_alloc_offset (offset of the new element, zero unless an allocate succeeded).
// The map sits in a RAM of 8-byte rows. One request is worked on at a time:
//   allocate: take the request, then a row scan, one row read per cycle,
//             that stops at the first fit (a run that crosses rows is tracked),
//             then a write of each row the element touches, then post the
//             result.
//   free:     take the request, write each row the element touches, post the result.
//   clear:    take the request, one row zeroed per cycle, then post the result.
// The scan over the RAM read port sets the allocate time.
// After reset a clearing pass over all ROWS rows (32 at 256 bytes) runs with s_ready low.
// The result sits in an output register, so the next request is taken while it
// waits; if the receiver stalls, the block finishes that request and then holds
// until the earlier result is taken.
module bitmap_first_fit_allocator_core
    import bffa_pkg::*;
#(
    parameter int POOL_BYTES = DEF_POOL_BYTES,
    parameter int ELEM_BYTES = DEF_ELEM_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_offset,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_ok,
    output logic [7:0] m_alloc_offset
);

    cmd_t  cmd;
    stat_t stat;

    bffa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .stat       (stat),
        .cmd        (cmd)
    );

    bffa_datapath #(
        .POOL_BYTES (POOL_BYTES),
        .ELEM_BYTES (ELEM_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_offset       (s_offset),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_ok           (m_ok),
        .m_alloc_offset (m_alloc_offset)
    );

`ifndef SYNTH
    // one request in flight: a transfer in closes the input until its result is posted
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a request is in flight");

    // a posted result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.clr, cmd.scan, cmd.mark, cmd.out_load}))
        else $error("conflicting datapath commands");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_alloc_offset == 8'd0))
        else $error("failed request carries an offset");
`endif

endmodule

[sv/bffa_datapath.sv]
module bffa_datapath
    import bffa_pkg::*;
#(
    parameter int POOL_BYTES = DEF_POOL_BYTES,
    parameter int ELEM_BYTES = DEF_ELEM_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_offset,
    input  logic       m_ready,
    output logic       m_valid,
    output logic       m_ok,
    output logic [7:0] m_alloc_offset
);

    localparam int ROWS  = (POOL_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = $clog2(ROW_BYTES);
    localparam int B_W   = ROW_W + COL_W;
    localparam int RC_W  = $clog2(ROWS + 1);
    localparam int CNT_W = $clog2(ELEM_BYTES + 1);
    localparam int CMP_W = ((B_W > 8) ? B_W : 8) + 1;
    localparam bit FITS  = (ELEM_BYTES <= POOL_BYTES);

    localparam logic [CMP_W-1:0] LAST_START = FITS ? CMP_W'(POOL_BYTES - ELEM_BYTES) : '0;
    localparam logic [B_W-1:0]   ELEM_M1    = B_W'(ELEM_BYTES - 1);
    localparam logic [B_W:0]     POOL_L     = (B_W + 1)'(POOL_BYTES);
    localparam logic [CNT_W-1:0] ELEM_C     = CNT_W'(ELEM_BYTES);
    localparam logic [RC_W-1:0]  ROWS_C     = RC_W'(ROWS);
    localparam logic [RC_W-1:0]  LAST_ROW_C = RC_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW_R = ROW_W'(ROWS - 1);

    logic [ROW_BYTES-1:0] map_mem [ROWS];

    logic [RC_W-1:0]      row_reg, row_next;
    logic [ROW_W-1:0]     rrow_reg, rrow_next;
    logic                 rvalid_reg, rvalid_next;
    logic [ROW_BYTES-1:0] rd_data_reg;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [B_W-1:0]       start_reg, start_next;
    logic [B_W-1:0]       end_reg, end_next;
    logic                 mark_val_reg, mark_val_next;
    logic                 res_ok_reg, res_ok_next;
    logic [7:0]           res_off_reg, res_off_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_ok_reg, m_ok_next;
    logic [7:0]           m_off_reg, m_off_next;

    logic                 free_ok;
    logic [B_W-1:0]       offset_b;
    logic                 issue;
    logic                 rd_en;
    logic                 wr_en;
    logic                 wr_val;
    logic [ROW_BYTES-1:0] wr_mask;
    logic [ROW_BYTES-1:0] mark_mask;
    logic [CNT_W-1:0]     scan_run;
    logic                 scan_hit;
    logic [B_W-1:0]       scan_pos;
    logic [B_W-1:0]       found_start;
    logic [CMP_W-1:0]     found_start_ext;

    assign offset_b        = B_W'(s_offset);
    assign free_ok         = FITS && (CMP_W'(s_offset) <= LAST_START);
    assign issue           = row_reg < ROWS_C;
    assign found_start     = scan_pos - ELEM_M1;
    assign found_start_ext = CMP_W'(found_start);

    // walk one row of the map; run length carries over from the previous row
    always_comb begin
        logic [CNT_W-1:0] r;
        logic             hit;
        logic [B_W-1:0]   pos;
        logic [B_W-1:0]   bidx;
        r   = run_reg;
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < ROW_BYTES; j++) begin
            bidx = {rrow_reg, COL_W'(j)};
            if (!hit) begin
                if (rd_data_reg[j] || ({1'b0, bidx} >= POOL_L)) begin
                    r = '0;
                end else begin
                    r = r + 1'b1;
                end
                if (r == ELEM_C) begin
                    hit = 1'b1;
                    pos = bidx;
                end
            end
        end
        scan_run = r;
        scan_hit = hit;
        scan_pos = pos;
    end

    always_comb begin
        logic [B_W-1:0] bidx;
        for (int j = 0; j < ROW_BYTES; j++) begin
            bidx         = {row_reg[ROW_W-1:0], COL_W'(j)};
            mark_mask[j] = (bidx >= start_reg) && (bidx <= end_reg);
        end
    end

    assign stat.fits      = FITS;
    assign stat.free_ok   = free_ok;
    assign stat.found     = rvalid_reg && scan_hit;
    assign stat.scan_last = rvalid_reg && (rrow_reg == LAST_ROW_R);
    assign stat.mark_last = row_reg[ROW_W-1:0] == end_reg[B_W-1:COL_W];
    assign stat.clr_last  = row_reg == LAST_ROW_C;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign rd_en   = cmd.scan && issue;
    assign wr_en   = cmd.clr || cmd.mark;
    assign wr_val  = cmd.mark && mark_val_reg;
    assign wr_mask = cmd.clr ? '1 : mark_mask;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int j = 0; j < ROW_BYTES; j++) begin
                if (wr_mask[j]) begin
                    map_mem[row_reg[ROW_W-1:0]][j] <= wr_val;
                end
            end
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[row_reg[ROW_W-1:0]];
        end
    end

    always_comb begin
        row_next      = row_reg;
        rrow_next     = rrow_reg;
        rvalid_next   = rvalid_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        mark_val_next = mark_val_reg;
        res_ok_next   = res_ok_reg;
        res_off_next  = res_off_reg;
        m_valid_next  = m_valid_reg;
        m_ok_next     = m_ok_reg;
        m_off_next    = m_off_reg;

        if (cmd.load) begin
            row_next      = (s_req_type == REQ_FREE) ? RC_W'(offset_b[B_W-1:COL_W]) : '0;
            rvalid_next   = 1'b0;
            run_next      = '0;
            start_next    = offset_b;
            end_next      = offset_b + ELEM_M1;
            mark_val_next = 1'b0;
            res_ok_next   = ((s_req_type == REQ_FREE) && free_ok) || (s_req_type == REQ_CLEAR);
            res_off_next  = '0;
        end

        if (cmd.scan) begin
            if (rvalid_reg && scan_hit) begin
                row_next      = RC_W'(found_start[B_W-1:COL_W]);
                rvalid_next   = 1'b0;
                start_next    = found_start;
                end_next      = scan_pos;
                mark_val_next = 1'b1;
                res_ok_next   = 1'b1;
                res_off_next  = found_start_ext[7:0];
            end else begin
                rvalid_next = issue;
                rrow_next   = row_reg[ROW_W-1:0];
                if (issue) begin
                    row_next = row_reg + 1'b1;
                end
                if (rvalid_reg) begin
                    run_next = scan_run;
                end
            end
        end

        if (cmd.clr || cmd.mark) begin
            row_next = row_reg + 1'b1;
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_ok_next    = res_ok_reg;
            m_off_next   = res_off_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rrow_reg     <= rrow_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        mark_val_reg <= mark_val_next;
        res_ok_reg   <= res_ok_next;
        res_off_reg  <= res_off_next;
        m_ok_reg     <= m_ok_next;
        m_off_reg    <= m_off_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_alloc_offset = m_off_reg;

endmodule

[sv/bffa_ctrl.sv]
module bffa_ctrl
    import bffa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_RST_CLR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (s_req_type)
                        REQ_ALLOC: state_next = stat.fits ? ST_SCAN : ST_DONE;
                        REQ_FREE:  state_next = stat.free_ok ? ST_MARK : ST_DONE;
                        REQ_CLEAR: state_next = ST_CLR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.found) begin
                    state_next = ST_MARK;
                end else if (stat.scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK: begin
                cmd.mark = 1'b1;
                if (stat.mark_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
